// ===== rtl/core/qos_map_dscp_to_priority_top_defines.svh =====
// ----------------------------------------------------------------------------
// qos map assertion macros
// shared assertion forms for the dscp to user-priority map block
// ----------------------------------------------------------------------------
`ifndef QOS_MAP_DSCP_TO_PRIORITY_TOP_DEFINES_SVH
`define QOS_MAP_DSCP_TO_PRIORITY_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QMAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qmap: same-cycle check failed");

// next-cycle implication, disabled in reset
`define QMAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qmap: next-cycle check failed");

`endif

// ===== rtl/core/qmap_pkg.sv =====
// ----------------------------------------------------------------------------
// qmap_pkg
// types, constants and default table for the dscp to user-priority map
// ----------------------------------------------------------------------------
package qmap_pkg;

  localparam int unsigned TABLE_ENTRIES  = 64;
  localparam int unsigned NUM_PRIORITIES = 8;
  localparam int unsigned ADDR_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned PRIO_W         = 8;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 8;

  localparam logic [7:0] LEN_MIN        = 8'd16;
  localparam logic [7:0] LEN_MAX        = 8'd58;
  localparam logic [7:0] UNMAPPED       = 8'hFF;
  localparam logic [7:0] ELEMENT_ID_RST = 8'd110;

  // rfc8325 defaults, unmapped code points hold 255
  localparam logic [7:0] DEFAULT_MAP [TABLE_ENTRIES] = '{
    8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd1, 8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
    8'd0, 8'd255, 8'd3,   8'd255, 8'd3,   8'd255, 8'd3,   8'd255,
    8'd4, 8'd255, 8'd4,   8'd255, 8'd4,   8'd255, 8'd4,   8'd255,
    8'd4, 8'd255, 8'd4,   8'd255, 8'd4,   8'd255, 8'd4,   8'd255,
    8'd5, 8'd255, 8'd255, 8'd255, 8'd6,   8'd255, 8'd6,   8'd255,
    8'd6, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  typedef enum logic [2:0] {
    ST_LOOKUP   = 3'd0,
    ST_TAKEN    = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_WRONG_ID = 3'd3,
    ST_BAD_LEN  = 3'd4,
    ST_IGNORED  = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_ID = 1'b0,
    CFG_AP_PRESENT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP
  } seq_state_e;

  // one table word: exception mark and priority
  typedef struct packed {
    logic              mark;
    logic [PRIO_W-1:0] prio;
  } qmap_word_t;

  // sequencer request to the table
  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    qmap_word_t        wr_data;
  } qmap_tbl_req_t;

endpackage

// ===== rtl/core/qmap_table.sv =====
// ----------------------------------------------------------------------------
// qmap_table
// 64-entry map store with per-entry valid bits; invalid entries read as
// the default map with no exception mark
// ----------------------------------------------------------------------------
module qmap_table (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qmap_pkg::qmap_tbl_req_t req_i,
  output qmap_pkg::qmap_word_t    rd_data_o
);
  import qmap_pkg::*;

  qmap_word_t                 mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_q;
  qmap_word_t                 rd_data_q;
  qmap_word_t                 dflt_word;

  // fallback word for an entry not written since the last reload
  always_comb begin
    dflt_word.mark = 1'b0;
    dflt_word.prio = DEFAULT_MAP[req_i.rd_addr];
  end

  // valid bits, cleared at once on reload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clear) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= valid_q[req_i.rd_addr] ? mem[req_i.rd_addr] : dflt_word;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/qmap_seq.sv =====
// ----------------------------------------------------------------------------
// qmap_seq
// element byte parser and sequencer: lookups, exception writes and the
// range sweep over table entries with one address counter and compare
// ----------------------------------------------------------------------------
`include "qos_map_dscp_to_priority_top_defines.svh"

module qmap_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            mode_i,
  input  logic [7:0]                      element_byte_i,
  input  logic                            first_byte_i,
  input  logic [7:0]                      lookup_dscp_i,
  input  logic [7:0]                      element_id_i,
  input  logic                            ap_present_i,
  input  qmap_pkg::qmap_word_t            rd_data_i,
  output qmap_pkg::qmap_tbl_req_t         req_o,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [qmap_pkg::PRIO_W-1:0]     user_priority_o,
  output logic [2:0]                      status_o
);
  import qmap_pkg::*;

  seq_state_e        state_q, state_d;
  logic              active_q, active_d;
  logic [5:0]        pos_q, pos_d;
  logic [4:0]        exc_cnt_q, exc_cnt_d;
  logic [7:0]        pend_q, pend_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic [ADDR_W-1:0] end_q, end_d;
  logic [2:0]        prio_q, prio_d;
  status_e           res_st_q, res_st_d;
  logic              done_q, done_d;
  logic [PRIO_W-1:0] up_q, up_d;
  status_e           st_q, st_d;

  logic              accept;
  logic [5:0]        body;
  logic [4:0]        pair;
  logic [4:0]        rng_idx;
  logic              in_exc;
  logic              last_rng;
  logic              len_bad;
  logic              dscp_in;
  logic              rng_go;
  logic [ADDR_W-1:0] rng_end;

  assign accept   = start_i && (state_q == S_IDLE);
  assign body     = pos_q - 6'd1;
  assign pair     = body[5:1];
  assign in_exc   = pair < exc_cnt_q;
  assign rng_idx  = pair - exc_cnt_q;
  assign last_rng = rng_idx >= 5'(NUM_PRIORITIES - 1);
  assign len_bad  = (element_byte_i < LEN_MIN) || (element_byte_i > LEN_MAX);
  assign dscp_in  = lookup_dscp_i < 8'(TABLE_ENTRIES);
  // a range touches the table only when low is a code point and high >= low
  assign rng_go   = (pend_q < 8'(TABLE_ENTRIES)) && (element_byte_i >= pend_q);
  assign rng_end  = (element_byte_i < 8'(TABLE_ENTRIES)) ?
                    element_byte_i[ADDR_W-1:0] : ADDR_W'(TABLE_ENTRIES - 1);

  // state and parse registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= 1'b0;
      pos_q     <= '0;
      exc_cnt_q <= '0;
      pend_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      pos_q     <= pos_d;
      exc_cnt_q <= exc_cnt_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  // sweep and result payload
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    end_q    <= end_d;
    prio_q   <= prio_d;
    res_st_q <= res_st_d;
    up_q     <= up_d;
    st_q     <= st_d;
  end

  // next state, table requests and result beat
  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    pos_d     = pos_q;
    exc_cnt_d = exc_cnt_q;
    pend_d    = pend_q;
    cur_d     = cur_q;
    end_d     = end_q;
    prio_d    = prio_q;
    res_st_d  = res_st_q;
    done_d    = 1'b0;
    up_d      = up_q;
    st_d      = st_q;
    req_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && mode_i) begin
          if (ap_present_i && dscp_in) begin
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = lookup_dscp_i[ADDR_W-1:0];
            state_d       = S_LOOK;
          end else begin
            done_d = 1'b1;
            up_d   = UNMAPPED;
            st_d   = ST_LOOKUP;
          end
        end else if (accept) begin
          up_d   = '0;
          done_d = 1'b1;
          st_d   = ST_TAKEN;
          if (first_byte_i) begin
            if (element_byte_i != element_id_i) begin
              active_d = 1'b0;
              st_d     = ST_WRONG_ID;
            end else begin
              active_d = 1'b1;
              pos_d    = '0;
            end
          end else if (!active_q) begin
            st_d = ST_IGNORED;
          end else if (pos_q == '0) begin
            // length byte: reload defaults on a good length
            if (len_bad) begin
              active_d = 1'b0;
              st_d     = ST_BAD_LEN;
            end else begin
              req_o.clear = 1'b1;
              exc_cnt_d   = 5'((element_byte_i - LEN_MIN) >> 1);
              pos_d       = 6'd1;
            end
          end else begin
            pos_d = pos_q + 6'd1;
            if (!body[0]) begin
              pend_d = element_byte_i;
            end else if (in_exc) begin
              // exception pair, only valid code point and priority
              if ((pend_q < 8'(TABLE_ENTRIES)) &&
                  (element_byte_i < 8'(NUM_PRIORITIES))) begin
                req_o.wr_en        = 1'b1;
                req_o.wr_addr      = pend_q[ADDR_W-1:0];
                req_o.wr_data.mark = 1'b1;
                req_o.wr_data.prio = element_byte_i;
              end
            end else begin
              if (last_rng) begin
                active_d = 1'b0;
                st_d     = ST_COMPLETE;
              end
              if (rng_go) begin
                // hold the beat back until the sweep ends
                done_d        = 1'b0;
                res_st_d      = last_rng ? ST_COMPLETE : ST_TAKEN;
                req_o.rd_en   = 1'b1;
                req_o.rd_addr = pend_q[ADDR_W-1:0];
                cur_d         = pend_q[ADDR_W-1:0];
                end_d         = rng_end;
                prio_d        = rng_idx[2:0];
                state_d       = S_SWEEP;
              end
            end
          end
        end
      end
      S_LOOK: begin
        done_d  = 1'b1;
        up_d    = rd_data_i.prio;
        st_d    = ST_LOOKUP;
        state_d = S_IDLE;
      end
      S_SWEEP: begin
        // read-modify-write, next entry read while this one is written
        if (!rd_data_i.mark) begin
          req_o.wr_en        = 1'b1;
          req_o.wr_addr      = cur_q;
          req_o.wr_data.mark = 1'b0;
          req_o.wr_data.prio = PRIO_W'(prio_q);
        end
        if (cur_q == end_q) begin
          done_d  = 1'b1;
          up_d    = '0;
          st_d    = res_st_q;
          state_d = S_IDLE;
        end else begin
          cur_d         = cur_q + ADDR_W'(1);
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = cur_q + ADDR_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign user_priority_o = up_q;
  assign status_o        = st_q;

  // checks
  `QMAP_ASSERT_NXT(a_no_ap_unmapped, clk_i, rst_ni, accept && mode_i && !ap_present_i, done_q && (up_q == UNMAPPED))
  `QMAP_ASSERT_IMP(a_sweep_in_bounds, clk_i, rst_ni, state_q == S_SWEEP, cur_q <= end_q)
  `QMAP_ASSERT_IMP(a_beat_when_idle, clk_i, rst_ni, done_q, state_q == S_IDLE)
  `QMAP_ASSERT_IMP(a_byte_prio_zero, clk_i, rst_ni, done_q && (st_q != ST_LOOKUP), up_q == '0)

endmodule

// ===== rtl/core/qos_map_dscp_to_priority_top.sv =====
// ----------------------------------------------------------------------------
// qos_map_dscp_to_priority_top
// dscp to 802.11 user-priority map, loaded from qos map set element bytes
// ----------------------------------------------------------------------------
// usage
//   command channel: an item is taken at a clock edge with start high and
//   busy low. mode_i 0 feeds one element byte (first_byte_i marks the id
//   byte), mode_i 1 looks up lookup_dscp_i.
//   result channel: every item gives one beat, shown for one cycle with
//   done_o high, carrying user_priority_o and status_o. the receiver
//   cannot stall it, so the beat must be captured in that cycle.
//   config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 element id, 1 ap present) at once; write only while idle.
// result path
//   element bytes without a range sweep: the beat is the result register
//   written at the take. lookup with an ap and dscp below 64: the beat
//   follows the registered read of the map store.
//   range pair: the sweep steps over the n entries the range covers
//   (at most 64), rewriting each unmarked one while the next is read.
//   busy drops as the beat is shown, so the next item may follow then.
// reset
//   map returns to the rfc8325 defaults, marks clear, parser idle,
//   element id 110, no ap.
// ----------------------------------------------------------------------------
module qos_map_dscp_to_priority_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode_i,
  input  logic [7:0]                      element_byte_i,
  input  logic                            first_byte_i,
  input  logic [7:0]                      lookup_dscp_i,
  output logic                            done_o,
  output logic [7:0]                      user_priority_o,
  output logic [2:0]                      status_o,
  input  logic                            cfg_we_i,
  input  logic [qmap_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qmap_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import qmap_pkg::*;

  logic [7:0]    element_id_q;
  logic          ap_present_q;
  qmap_tbl_req_t tbl_req;
  qmap_word_t    tbl_rd_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_id_q <= ELEMENT_ID_RST;
      ap_present_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ELEMENT_ID: element_id_q <= cfg_wdata_i;
        CFG_AP_PRESENT: ap_present_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // parser and sweep sequencer
  qmap_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .mode_i          (mode_i),
    .element_byte_i  (element_byte_i),
    .first_byte_i    (first_byte_i),
    .lookup_dscp_i   (lookup_dscp_i),
    .element_id_i    (element_id_q),
    .ap_present_i    (ap_present_q),
    .rd_data_i       (tbl_rd_data),
    .req_o           (tbl_req),
    .busy_o          (busy),
    .done_o          (done_o),
    .user_priority_o (user_priority_o),
    .status_o        (status_o)
  );

  // map store
  qmap_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (tbl_rd_data)
  );

endmodule
